// ----- rtl/core/ngac_pkg.sv -----
// Shared types, constants and helper functions for the nine-grid area change block.
// Used by every module under rtl/core but ngac_div; depends on nothing else.
package ngac_pkg;

  // Field widths
  localparam int UID_W      = 16;
  localparam int POS_W      = 16;
  localparam int OLD_W      = 21;
  localparam int AREA_W     = 20;
  localparam int ACT_W      = 2;
  localparam int GRID_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Derived widths: clamped position plus one, full new area, area row
  localparam int VPOS_W = POS_W + 1;
  localparam int NEWA_W = VPOS_W + GRID_W + 1;
  localparam int ROW_W  = 21;
  localparam int SLOTS  = 9;
  localparam int SLOT_W = 4;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LEAVE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ENTER = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESET = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AREAS_ACROSS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREAS_DOWN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_LIMIT   = 3'd4;

  // Register reset values
  localparam logic [GRID_W-1:0] RST_AREAS_ACROSS = 11'd16;
  localparam logic [GRID_W-1:0] RST_AREAS_DOWN   = 11'd16;
  localparam logic [POS_W-1:0]  RST_MAP_WIDTH    = 16'd512;
  localparam logic [POS_W-1:0]  RST_MAP_HEIGHT   = 16'd512;
  localparam logic [UID_W-1:0]  RST_UNIT_LIMIT   = 16'd4096;

  // Default parameter values
  localparam int DEF_CELL_WIDTH  = 32;
  localparam int DEF_CELL_HEIGHT = 32;
  localparam int DEF_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [GRID_W-1:0] areas_across;
    logic [GRID_W-1:0] areas_down;
    logic [POS_W-1:0]  map_width;
    logic [POS_W-1:0]  map_height;
    logic [UID_W-1:0]  unit_limit;
  } cfg_t;

  // One classified request: the three slot masks select which of the nine
  // neighbors are sent as leave, enter and reset.
  typedef struct packed {
    logic [UID_W-1:0]  unit_tag;
    logic [AREA_W-1:0] new_area;
    logic [AREA_W-1:0] old_base;
    logic [SLOTS-1:0]  leave;
    logic [SLOTS-1:0]  enter;
    logic [SLOTS-1:0]  rst;
  } entry_t;

  // Slots are scanned with x outer and y inner: column is the x offset index.
  function automatic logic [1:0] slot_col(input logic [SLOT_W-1:0] s);
    logic [1:0] c;
    case (s)
      4'd0, 4'd1, 4'd2: c = 2'd0;
      4'd3, 4'd4, 4'd5: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] slot_row(input logic [SLOT_W-1:0] s);
    logic [1:0] r;
    case (s)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // Offset index 0, 1, 2 as a signed step of -1, 0, +1.
  function automatic logic signed [1:0] idx_off(input logic [1:0] i);
    logic signed [1:0] o;
    case (i)
      2'd0:    o = 2'sb11;
      2'd1:    o = 2'sb00;
      default: o = 2'sb01;
    endcase
    return o;
  endfunction

  // Saturate a coordinate difference to the range -3..3.
  function automatic logic signed [2:0] clamp3(input logic signed [ROW_W:0] d);
    logic signed [2:0] c;
    if (d > 22'sd3) begin
      c = 3'sb011;
    end else if (d < -22'sd3) begin
      c = 3'sb101;
    end else begin
      c = d[2:0];
    end
    return c;
  endfunction

  // True when a coordinate difference plus a step stays within one cell.
  function automatic logic near(input logic signed [2:0] d, input logic signed [1:0] step);
    logic signed [3:0] sum;
    sum = $signed({d[2], d}) + $signed({{2{step[1]}}, step});
    return (sum >= -4'sd1) && (sum <= 4'sd1);
  endfunction

endpackage

// ----- rtl/core/ngac_div.sv -----
// Iterative unsigned divider, two quotient bits per cycle.
// Depends on nothing but its parameters; used by the front end.
module ngac_div #(
  parameter int DW = 20,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);
  localparam int STEPS = (DW + 1) / 2;
  localparam int PW    = 2 * STEPS;
  localparam int CW    = $clog2(STEPS + 1);

  logic [PW-1:0] sh_r, sh_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;

  // Two restoring steps: shift in a dividend bit, subtract when it fits.
  always_comb begin
    logic [VW:0]   part;
    logic          q_hi;
    logic          q_lo;
    part = {rem_r, sh_r[PW-1]};
    q_hi = part >= {1'b0, dvs_r};
    if (q_hi) begin
      part = part - {1'b0, dvs_r};
    end
    part = {part[VW-1:0], sh_r[PW-2]};
    q_lo = part >= {1'b0, dvs_r};
    if (q_lo) begin
      part = part - {1'b0, dvs_r};
    end
    rem_nxt = part[VW-1:0];
    sh_nxt  = {sh_r[PW-3:0], q_hi, q_lo};
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Working registers: the dividend shifts out as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= PW'(dividend);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      sh_r  <= sh_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign quot = sh_r[DW-1:0];
  assign rem  = rem_r;

endmodule

// ----- rtl/core/ngac_front.sv -----
// Front end: accepts a request, computes the new area, splits both areas into
// grid coordinates and classifies the nine neighbors. Uses ngac_pkg and ngac_div.
module ngac_front #(
  parameter int CELL_WIDTH  = ngac_pkg::DEF_CELL_WIDTH,
  parameter int CELL_HEIGHT = ngac_pkg::DEF_CELL_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ngac_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ngac_pkg::UID_W-1:0]    in_unit_id,
  input  logic [ngac_pkg::POS_W-1:0]    in_pos_x,
  input  logic [ngac_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [ngac_pkg::OLD_W-1:0] in_old_area,
  input  logic                          in_force_reset,
  output logic                          q_push,
  output ngac_pkg::entry_t              q_data,
  input  logic                          q_full
);
  import ngac_pkg::*;

  // Constant division by a cell size as a multiply by its rounded-up reciprocal.
  localparam int SHIFT_X = VPOS_W + $clog2(CELL_WIDTH);
  localparam int SHIFT_Y = VPOS_W + $clog2(CELL_HEIGHT);
  localparam int RECIP_W = VPOS_W + 2;
  localparam int PROD_W  = VPOS_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_X =
    RECIP_W'(((64'd1 << SHIFT_X) + 64'(CELL_WIDTH) - 64'd1) / 64'(CELL_WIDTH));
  localparam logic [RECIP_W-1:0] RECIP_Y =
    RECIP_W'(((64'd1 << SHIFT_Y) + 64'(CELL_HEIGHT) - 64'd1) / 64'(CELL_HEIGHT));

  // Front-end states
  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_RECIP = 3'd1;
  localparam logic [2:0] F_MUL   = 3'd2;
  localparam logic [2:0] F_DIV   = 3'd3;
  localparam logic [2:0] F_MASK  = 3'd4;
  localparam logic [2:0] F_PUSH  = 3'd5;

  logic [2:0]         fstate_r, fstate_nxt;
  logic [UID_W-1:0]   uid_r;
  logic               uid_ok_r;
  logic [VPOS_W-1:0]  vx_r, vy_r;
  logic [OLD_W-1:0]   old_r;
  logic               force_r;
  logic [VPOS_W-1:0]  gx_r, gy_r;
  logic [NEWA_W-1:0]  newa_r;
  logic [ROW_W-1:0]   ayn_r;
  entry_t             entry_r;
  logic               push_r;

  logic               accept;
  logic [VPOS_W-1:0]  vx_in, vy_in;
  logic [PROD_W-1:0]  prod_x, prod_y;
  logic               old_pos;
  logic [AREA_W-1:0]  old_base;
  logic               div_start;
  logic               busy_o, busy_n;
  logic [AREA_W-1:0]  quot_o, quot_n;
  logic [GRID_W-1:0]  rem_o, rem_n;
  entry_t             entry_nxt;
  logic               push_nxt;

  assign in_stall = (fstate_r != F_IDLE);
  assign accept   = in_valid && !in_stall;

  // Clamp to the map and add one; a coordinate past the map becomes the map size.
  assign vx_in = (in_pos_x >= cfg.map_width)  ? VPOS_W'(cfg.map_width)  : VPOS_W'(in_pos_x) + 1'b1;
  assign vy_in = (in_pos_y >= cfg.map_height) ? VPOS_W'(cfg.map_height) : VPOS_W'(in_pos_y) + 1'b1;

  assign prod_x = PROD_W'(vx_r) * PROD_W'(RECIP_X);
  assign prod_y = PROD_W'(vy_r) * PROD_W'(RECIP_Y);

  // A negative or zero old area sits at grid position (0,0).
  assign old_pos  = !old_r[OLD_W-1] && (old_r[AREA_W-1:0] != '0);
  assign old_base = old_pos ? old_r[AREA_W-1:0] : '0;

  assign div_start = (fstate_r == F_MUL);

  // Old area splits into (column, row); the new column folds into the row.
  ngac_div #(.DW(AREA_W), .VW(GRID_W)) u_div_old (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (old_base),
    .divisor  (cfg.areas_across),
    .busy     (busy_o),
    .quot     (quot_o),
    .rem      (rem_o)
  );

  ngac_div #(.DW(AREA_W), .VW(GRID_W)) u_div_new (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (AREA_W'(gx_r)),
    .divisor  (cfg.areas_across),
    .busy     (busy_n),
    .quot     (quot_n),
    .rem      (rem_n)
  );

  // Classify the nine neighbors of both areas into leave, enter and reset.
  always_comb begin
    logic               gate;
    logic [ROW_W-1:0]   ayo;
    logic [2:0]         ox_ok, oy_ok, nx_ok, ny_ok;
    logic signed [2:0]  dxo, dyo, dxn, dyn;
    logic [1:0]         c, r;
    logic               vo, vn, ov, nv;
    logic               equal;
    gate = (cfg.areas_across != '0) && (cfg.areas_down != '0);
    ayo  = ROW_W'(quot_o);

    // The row above a center exists only when it is inside the grid, which
    // also holds for a center row that lies below the grid.
    ox_ok[0] = (rem_o != '0);
    ox_ok[1] = 1'b1;
    ox_ok[2] = ({1'b0, rem_o} + 1'b1) < {1'b0, cfg.areas_across};
    oy_ok[0] = (ayo != '0) && (ayo <= ROW_W'(cfg.areas_down));
    oy_ok[1] = ayo < ROW_W'(cfg.areas_down);
    oy_ok[2] = ({1'b0, ayo} + 1'b1) < (ROW_W + 1)'(cfg.areas_down);

    nx_ok[0] = (rem_n != '0);
    nx_ok[1] = 1'b1;
    nx_ok[2] = ({1'b0, rem_n} + 1'b1) < {1'b0, cfg.areas_across};
    ny_ok[0] = (ayn_r != '0) && (ayn_r <= ROW_W'(cfg.areas_down));
    ny_ok[1] = ayn_r < ROW_W'(cfg.areas_down);
    ny_ok[2] = ({1'b0, ayn_r} + 1'b1) < (ROW_W + 1)'(cfg.areas_down);

    dxo = clamp3($signed((ROW_W + 1)'(rem_o)) - $signed((ROW_W + 1)'(rem_n)));
    dxn = clamp3($signed((ROW_W + 1)'(rem_n)) - $signed((ROW_W + 1)'(rem_o)));
    dyo = clamp3($signed({1'b0, ayo}) - $signed({1'b0, ayn_r}));
    dyn = clamp3($signed({1'b0, ayn_r}) - $signed({1'b0, ayo}));

    entry_nxt          = '0;
    entry_nxt.unit_tag = uid_r;
    entry_nxt.new_area = newa_r[AREA_W-1:0];
    entry_nxt.old_base = old_base;
    for (int s = 0; s < SLOTS; s++) begin
      c  = slot_col(SLOT_W'(s));
      r  = slot_row(SLOT_W'(s));
      vo = gate && ox_ok[c] && oy_ok[r];
      vn = gate && nx_ok[c] && ny_ok[r];
      ov = near(dxo, idx_off(c)) && near(dyo, idx_off(r));
      nv = near(dxn, idx_off(c)) && near(dyn, idx_off(r));
      entry_nxt.leave[s] = vo && !ov;
      entry_nxt.rst[s]   = vo && ov;
      entry_nxt.enter[s] = vn && !nv;
    end

    // Unchanged area without the force flag, or a bad unit id, sends nothing.
    equal    = !old_r[OLD_W-1] && ({{(NEWA_W - AREA_W){1'b0}}, old_r[AREA_W-1:0]} == newa_r);
    push_nxt = uid_ok_r && !(equal && !force_r) &&
               ({entry_nxt.leave, entry_nxt.enter, entry_nxt.rst} != '0);
  end

  // Sequencer for one request at a time.
  always_comb begin
    fstate_nxt = fstate_r;
    case (fstate_r)
      F_IDLE:  if (accept) fstate_nxt = F_RECIP;
      F_RECIP: fstate_nxt = F_MUL;
      F_MUL:   fstate_nxt = F_DIV;
      F_DIV:   if (!busy_o && !busy_n) fstate_nxt = F_MASK;
      F_MASK:  fstate_nxt = push_nxt ? F_PUSH : F_IDLE;
      F_PUSH:  if (!q_full) fstate_nxt = F_IDLE;
      default: fstate_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fstate_r <= F_IDLE;
      push_r   <= 1'b0;
    end else begin
      fstate_r <= fstate_nxt;
      if (fstate_r == F_MASK) begin
        push_r <= push_nxt;
      end else if (fstate_r == F_PUSH && !q_full) begin
        push_r <= 1'b0;
      end
    end
  end

  // Datapath registers along the sequence.
  always_ff @(posedge clk) begin
    if (accept) begin
      uid_r    <= in_unit_id;
      uid_ok_r <= in_unit_id < cfg.unit_limit;
      vx_r     <= vx_in;
      vy_r     <= vy_in;
      old_r    <= in_old_area;
      force_r  <= in_force_reset;
    end
    if (fstate_r == F_RECIP) begin
      gx_r <= VPOS_W'(prod_x >> SHIFT_X);
      gy_r <= VPOS_W'(prod_y >> SHIFT_Y);
    end
    if (fstate_r == F_MUL) begin
      newa_r <= NEWA_W'(gy_r) * NEWA_W'(cfg.areas_across) + NEWA_W'(gx_r);
    end
    if (fstate_r == F_DIV && !busy_n) begin
      ayn_r <= ROW_W'(gy_r) + ROW_W'(quot_n);
    end
    if (fstate_r == F_MASK) begin
      entry_r <= entry_nxt;
    end
  end

  assign q_push = (fstate_r == F_PUSH) && push_r && !q_full;
  assign q_data = entry_r;

endmodule

// ----- rtl/core/ngac_queue.sv -----
// Short queue of classified requests between the front and back ends.
// Uses ngac_pkg for the entry type.
module ngac_queue #(
  parameter int DEPTH = ngac_pkg::DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ngac_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output ngac_pkg::entry_t pop_data,
  output logic             empty
);
  import ngac_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slots_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/ngac_back.sv -----
// Back end: walks the slot masks of one request and sends one result per cycle unless out_stall holds it.
// Uses ngac_pkg for the entry type, action codes and slot tables.
module ngac_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ngac_pkg::GRID_W-1:0]    areas_across,
  input  logic                           q_valid,
  input  ngac_pkg::entry_t               q_data,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ngac_pkg::UID_W-1:0]     out_unit_tag,
  output logic [ngac_pkg::ACT_W-1:0]     out_action,
  output logic [ngac_pkg::AREA_W-1:0]    out_target_area,
  output logic [ngac_pkg::AREA_W-1:0]    out_new_area,
  output logic                           out_last
);
  import ngac_pkg::*;

  entry_t             cur_r;
  logic               out_valid_r;
  logic [UID_W-1:0]   out_tag_r;
  logic [ACT_W-1:0]   out_act_r;
  logic [AREA_W-1:0]  out_target_r;
  logic [AREA_W-1:0]  out_newa_r;
  logic               out_last_r;

  logic               cur_any, rest_any, emit, load;
  logic [ACT_W-1:0]   act;
  logic [SLOTS-1:0]   sel_mask, pick;
  logic [SLOT_W-1:0]  slot;
  logic [AREA_W-1:0]  base, target;
  entry_t             cur_nxt;

  // Leave slots go first, then enter, then reset; lowest slot first.
  always_comb begin
    logic [1:0]        c, r;
    logic [AREA_W-1:0] across20, dxe, rowoff;
    if (cur_r.leave != '0) begin
      act      = ACT_LEAVE;
      sel_mask = cur_r.leave;
      base     = cur_r.old_base;
    end else if (cur_r.enter != '0) begin
      act      = ACT_ENTER;
      sel_mask = cur_r.enter;
      base     = cur_r.new_area;
    end else begin
      act      = ACT_RESET;
      sel_mask = cur_r.rst;
      base     = cur_r.old_base;
    end

    pick = '0;
    slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (sel_mask[s]) begin
        pick = '0;
        pick[s] = 1'b1;
        slot = SLOT_W'(s);
      end
    end

    // Neighbor area: base plus the x step plus one row up or down.
    c        = slot_col(slot);
    r        = slot_row(slot);
    across20 = AREA_W'(areas_across);
    case (c)
      2'd0:    dxe = '1;
      2'd2:    dxe = AREA_W'(1);
      default: dxe = '0;
    endcase
    case (r)
      2'd0:    rowoff = ~across20 + 1'b1;
      2'd2:    rowoff = across20;
      default: rowoff = '0;
    endcase
    target = base + dxe + rowoff;

    cur_nxt = cur_r;
    case (act)
      ACT_LEAVE: cur_nxt.leave = cur_r.leave & ~pick;
      ACT_ENTER: cur_nxt.enter = cur_r.enter & ~pick;
      default:   cur_nxt.rst   = cur_r.rst & ~pick;
    endcase
  end

  assign cur_any  = ({cur_r.leave, cur_r.enter, cur_r.rst} != '0);
  assign rest_any = ({cur_nxt.leave, cur_nxt.enter, cur_nxt.rst} != '0);
  assign emit     = cur_any && (!out_valid_r || !out_stall);
  // Take the next request as the current one sends its final result.
  assign load     = q_valid && (!cur_any || (emit && !rest_any));
  assign q_pop    = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        cur_r <= q_data;
      end else if (emit) begin
        cur_r <= cur_nxt;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register holds while the result is stalled.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_tag_r    <= cur_r.unit_tag;
      out_act_r    <= act;
      out_target_r <= target;
      out_newa_r   <= cur_r.new_area;
      out_last_r   <= !rest_any;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_unit_tag    = out_tag_r;
  assign out_action      = out_act_r;
  assign out_target_area = out_target_r;
  assign out_new_area    = out_newa_r;
  assign out_last        = out_last_r;

endmodule

// ----- rtl/core/nine_grid_area_change_diff_top.sv -----
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_stall   unit_id, pos_x, pos_y, old_area, force_reset
// out      out  out_valid / out_stall unit_tag, action, target_area, new_area, last
// cfg      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// The front end takes a new request only once it is done with the last one; it
// waits on its two 10-step dividers, which run side by side, and on a full queue.
// The back end sends one result per cycle while out_stall is low, up to 18 per request,
// so the output channel can limit the sustained rate of requests.
// A two-entry queue lets the front end classify the next request while results go out.
// Reset is synchronous on rst_n and returns the registers to their defaults.
// Output stalls back up into the queue and then into in_stall.
//
// Top level of the nine-grid area change block; holds the configuration registers.
// Depends on ngac_pkg, ngac_front, ngac_queue and ngac_back.
module nine_grid_area_change_diff_top #(
  parameter int CELL_WIDTH  = ngac_pkg::DEF_CELL_WIDTH,
  parameter int CELL_HEIGHT = ngac_pkg::DEF_CELL_HEIGHT,
  parameter int QUEUE_DEPTH = ngac_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ngac_pkg::UID_W-1:0]        in_unit_id,
  input  logic [ngac_pkg::POS_W-1:0]        in_pos_x,
  input  logic [ngac_pkg::POS_W-1:0]        in_pos_y,
  input  logic signed [ngac_pkg::OLD_W-1:0] in_old_area,
  input  logic                              in_force_reset,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ngac_pkg::UID_W-1:0]        out_unit_tag,
  output logic [ngac_pkg::ACT_W-1:0]        out_action,
  output logic [ngac_pkg::AREA_W-1:0]       out_target_area,
  output logic [ngac_pkg::AREA_W-1:0]       out_new_area,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ngac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ngac_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ngac_pkg::*;

  cfg_t    cfg_r;
  logic    q_push, q_full, q_pop, q_empty;
  entry_t  q_in, q_out;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.areas_across <= RST_AREAS_ACROSS;
      cfg_r.areas_down   <= RST_AREAS_DOWN;
      cfg_r.map_width    <= RST_MAP_WIDTH;
      cfg_r.map_height   <= RST_MAP_HEIGHT;
      cfg_r.unit_limit   <= RST_UNIT_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AREAS_ACROSS: cfg_r.areas_across <= cfg_data[GRID_W-1:0];
        CFG_AREAS_DOWN:   cfg_r.areas_down   <= cfg_data[GRID_W-1:0];
        CFG_MAP_WIDTH:    cfg_r.map_width    <= cfg_data;
        CFG_MAP_HEIGHT:   cfg_r.map_height   <= cfg_data;
        CFG_UNIT_LIMIT:   cfg_r.unit_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  ngac_front #(
    .CELL_WIDTH  (CELL_WIDTH),
    .CELL_HEIGHT (CELL_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_unit_id     (in_unit_id),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_old_area    (in_old_area),
    .in_force_reset (in_force_reset),
    .q_push         (q_push),
    .q_data         (q_in),
    .q_full         (q_full)
  );

  ngac_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  ngac_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .areas_across    (cfg_r.areas_across),
    .q_valid         (!q_empty),
    .q_data          (q_out),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_unit_tag    (out_unit_tag),
    .out_action      (out_action),
    .out_target_area (out_target_area),
    .out_new_area    (out_new_area),
    .out_last        (out_last)
  );

  // The front end never writes a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  // The back end never takes from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  // Within one request, results keep the unit and never step back in action.
  a_item_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=>
      (!out_valid || ((out_action >= $past(out_action)) &&
                      (out_unit_tag == $past(out_unit_tag)))))
    else $error("results of one request out of order");

endmodule

// ----- tb/sv/tb_nine_grid_area_change_diff_top.sv -----
// Self-checking testbench for nine_grid_area_change_diff_top: directed and random moves
// over several grid settings, checked against an in-bench predictor of the area changes.
// Depends on ngac_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_nine_grid_area_change_diff_top;
  import ngac_pkg::*;

  localparam int CELL_W         = DEF_CELL_WIDTH;
  localparam int CELL_H         = DEF_CELL_HEIGHT;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int PRINT_CAP      = 40;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  typedef struct packed {
    logic [UID_W-1:0]  unit_tag;
    logic [ACT_W-1:0]  action;
    logic [AREA_W-1:0] target_area;
    logic [AREA_W-1:0] new_area;
    logic              last;
  } area_move_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [UID_W-1:0]      in_unit_id = '0;
  logic [POS_W-1:0]      in_pos_x = '0;
  logic [POS_W-1:0]      in_pos_y = '0;
  logic signed [OLD_W-1:0] in_old_area = '0;
  logic                  in_force_reset = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [UID_W-1:0]      out_unit_tag;
  logic [ACT_W-1:0]      out_action;
  logic [AREA_W-1:0]     out_target_area;
  logic [AREA_W-1:0]     out_new_area;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the block's registers and the queue of predicted area moves.
  cfg_t        grid_cfg = '{RST_AREAS_ACROSS, RST_AREAS_DOWN, RST_MAP_WIDTH,
                            RST_MAP_HEIGHT, RST_UNIT_LIMIT};
  area_move_t  expected_moves [$];
  int          err_count = 0;
  int          quiet_cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          gap_max = 0;
  int          burst_left = 0;

  nine_grid_area_change_diff_top #(
    .CELL_WIDTH (CELL_W),
    .CELL_HEIGHT(CELL_H)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_unit_id     (in_unit_id),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_old_area    (in_old_area),
    .in_force_reset (in_force_reset),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_unit_tag   (out_unit_tag),
    .out_action     (out_action),
    .out_target_area(out_target_area),
    .out_new_area   (out_new_area),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Area of a clamped position, at full precision.
  function automatic longint grid_area_of(input logic [POS_W-1:0] px,
                                          input logic [POS_W-1:0] py);
    longint vx, vy;
    vx = (px >= grid_cfg.map_width) ? longint'(grid_cfg.map_width) : longint'(px) + 1;
    vy = (py >= grid_cfg.map_height) ? longint'(grid_cfg.map_height) : longint'(py) + 1;
    return (vy / CELL_H) * longint'(grid_cfg.areas_across) + vx / CELL_W;
  endfunction

  // Work out the leave, enter and reset moves caused by one accepted request.
  function automatic void predict_moves(input logic [UID_W-1:0] uid,
                                        input logic [POS_W-1:0] px,
                                        input logic [POS_W-1:0] py,
                                        input logic signed [OLD_W-1:0] old_raw,
                                        input logic force_rst);
    longint     acr, dwn, old_a, new_a, ax, ay, cx, cy;
    longint     ctr [2];
    longint     ring [2][9];
    int         cnt [2];
    bit         lone_old [9];
    bit         lone_new [9];
    bit         shared [9];
    area_move_t moves [18];
    int         k, w, i, j;
    if (uid >= grid_cfg.unit_limit) return;
    acr = longint'(grid_cfg.areas_across);
    dwn = longint'(grid_cfg.areas_down);
    old_a = longint'(old_raw);
    new_a = grid_area_of(px, py);
    if (old_a == new_a && !force_rst) return;
    ctr[0] = old_a;
    ctr[1] = new_a;

    // In-grid 3x3 neighborhoods, x outer and y inner; a nonpositive area sits at (0,0).
    for (w = 0; w < 2; w++) begin
      cnt[w] = 0;
      ax = 0;
      ay = 0;
      if (acr != 0 && dwn != 0) begin
        if (ctr[w] > 0) begin
          ax = ctr[w] % acr;
          ay = ctr[w] / acr;
        end
        for (cx = ax - 1; cx <= ax + 1; cx++) begin
          if (cx >= 0 && cx < acr) begin
            for (cy = ay - 1; cy <= ay + 1; cy++) begin
              if (cy >= 0 && cy < dwn) begin
                ring[w][cnt[w]] = cy * acr + cx;
                cnt[w]++;
              end
            end
          end
        end
      end
    end

    k = 0;
    if (old_a == new_a) begin
      // Unchanged area with the flag set: the old neighborhood is reset.
      for (i = 0; i < cnt[0]; i++) begin
        moves[k] = '{uid, ACT_RESET, AREA_W'(ring[0][i]), AREA_W'(new_a), 1'b0};
        k++;
      end
    end else begin
      for (i = 0; i < 9; i++) begin
        lone_old[i] = 1'b1;
        lone_new[i] = 1'b1;
        shared[i] = 1'b0;
      end
      for (i = 0; i < cnt[0]; i++) begin
        for (j = 0; j < cnt[1]; j++) begin
          if (lone_old[i] && lone_new[j] && ring[0][i] == ring[1][j]) begin
            shared[i] = 1'b1;
            lone_old[i] = 1'b0;
            lone_new[j] = 1'b0;
          end
        end
      end
      for (i = 0; i < cnt[0]; i++) begin
        if (lone_old[i]) begin
          moves[k] = '{uid, ACT_LEAVE, AREA_W'(ring[0][i]), AREA_W'(new_a), 1'b0};
          k++;
        end
      end
      for (j = 0; j < cnt[1]; j++) begin
        if (lone_new[j]) begin
          moves[k] = '{uid, ACT_ENTER, AREA_W'(ring[1][j]), AREA_W'(new_a), 1'b0};
          k++;
        end
      end
      for (i = 0; i < cnt[0]; i++) begin
        if (shared[i]) begin
          moves[k] = '{uid, ACT_RESET, AREA_W'(ring[0][i]), AREA_W'(new_a), 1'b0};
          k++;
        end
      end
    end
    if (k > 0) moves[k-1].last = 1'b1;
    for (i = 0; i < k; i++) expected_moves.push_back(moves[i]);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    if (err_count <= PRINT_CAP) begin
      $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  // Receiver stall pattern: runs of stall or no stall whose mix depends on the mode.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      case (stall_mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
          stall_left <= 8;
        end
        STALL_LIGHT: begin
          out_stall <= ($urandom_range(0, 3) == 0);
          stall_left <= $urandom_range(1, 4);
        end
        default: begin
          out_stall <= ($urandom_range(0, 1) == 0);
          stall_left <= $urandom_range(1, 24);
        end
      endcase
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Result checker: signals are stable at the falling edge and are taken at the next rise.
  always @(negedge clk) begin : check_results
    area_move_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_moves.size() == 0) begin
        report_mismatch("result with nothing pending, unit_tag", out_unit_tag, 0);
      end else begin
        want = expected_moves.pop_front();
        if (out_unit_tag !== want.unit_tag)
          report_mismatch("unit_tag", out_unit_tag, want.unit_tag);
        if (out_action !== want.action)
          report_mismatch("action", out_action, want.action);
        if (out_target_area !== want.target_area)
          report_mismatch("target_area", out_target_area, want.target_area);
        if (out_new_area !== want.new_area)
          report_mismatch("new_area", out_new_area, want.new_area);
        if (out_last !== want.last)
          report_mismatch("last", out_last, want.last);
      end
    end
  end

  // Watchdog on cycles in which no request of any channel is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Send one move request; the sender pauses at random between bursts.
  task automatic send_move(input logic [UID_W-1:0] uid, input logic [POS_W-1:0] px,
                           input logic [POS_W-1:0] py, input logic signed [OLD_W-1:0] old_a,
                           input logic force_rst);
    bit taken;
    int gap;
    in_valid <= 1'b1;
    in_unit_id <= uid;
    in_pos_x <= px;
    in_pos_y <= py;
    in_old_area <= old_a;
    in_force_reset <= force_rst;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    predict_moves(uid, px, py, old_a, force_rst);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Register write request; the caller lowers cfg_valid after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    case (idx)
      CFG_AREAS_ACROSS: grid_cfg.areas_across = GRID_W'(value);
      CFG_AREAS_DOWN:   grid_cfg.areas_down = GRID_W'(value);
      CFG_MAP_WIDTH:    grid_cfg.map_width = POS_W'(value);
      CFG_MAP_HEIGHT:   grid_cfg.map_height = POS_W'(value);
      CFG_UNIT_LIMIT:   grid_cfg.unit_limit = UID_W'(value);
      default: ;
    endcase
  endtask

  // Program the whole grid; only called while the block is idle.
  task automatic load_grid(input int across, input int down, input int mw, input int mh,
                           input int lim);
    write_reg(CFG_AREAS_ACROSS, across);
    write_reg(CFG_AREAS_DOWN, down);
    write_reg(CFG_MAP_WIDTH, mw);
    write_reg(CFG_MAP_HEIGHT, mh);
    write_reg(CFG_UNIT_LIMIT, lim);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, wait for every predicted move, then let requests with no moves finish.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Coordinate mostly inside the map, sometimes anywhere, sometimes at an edge.
  function automatic logic [POS_W-1:0] pick_coord(input logic [POS_W-1:0] size);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return POS_W'($urandom_range(0, int'(size) - 1));
    if (sel < 85) return POS_W'($urandom);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return size - 1'b1;
      2:       return size;
      default: return '1;
    endcase
  endfunction

  // Random move whose old area is mostly the same as or close to the new one.
  task automatic send_random_move();
    logic [UID_W-1:0]        uid;
    logic [POS_W-1:0]        px, py;
    logic signed [OLD_W-1:0] old_a;
    longint                  na, cand;
    int                      sel, lim;
    lim = int'(grid_cfg.unit_limit);
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      uid = UID_W'($urandom_range(65535, lim));
    end else if (sel < 12) begin
      uid = ($urandom_range(0, 1) != 0) ? '1 : UID_W'(lim - 1);
    end else begin
      uid = UID_W'($urandom_range(0, lim - 1));
    end
    px = pick_coord(grid_cfg.map_width);
    py = pick_coord(grid_cfg.map_height);
    na = grid_area_of(px, py);
    sel = $urandom_range(0, 99);
    if (sel < 22) begin
      cand = na;
    end else if (sel < 62) begin
      cand = na + (longint'($urandom_range(0, 4)) - 2)
           + (longint'($urandom_range(0, 4)) - 2) * longint'(grid_cfg.areas_across);
    end else if (sel < 72) begin
      cand = -1;
    end else if (sel < 77) begin
      cand = 0;
    end else begin
      cand = longint'($urandom_range(0, 1048575));
    end
    if (cand < -1 || cand > 1048575) cand = longint'($urandom_range(0, 1048575));
    old_a = OLD_W'(cand);
    send_move(uid, px, py, old_a, 1'($urandom_range(0, 1)));
  endtask

  // Random moves, with the idle pattern of both sides reshuffled every 30 requests.
  task automatic run_random_moves(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      if (n % 30 == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        case ($urandom_range(0, 2))
          0:       gap_max = 0;
          1:       gap_max = 4;
          default: gap_max = 20;
        endcase
      end
      send_random_move();
    end
    drain_and_settle();
  endtask

  // Directed moves on the reset grid of 16 x 16 areas over a 512 x 512 map.
  task automatic test_reset_grid();
    stall_mode = STALL_LIGHT;
    gap_max = 3;
    // No old area at the origin, then a first placement further in.
    send_move(16'd0, 16'd0, 16'd0, -21'sd1, 1'b0);
    send_move(16'd4095, 16'd100, 16'd100, -21'sd1, 1'b0);
    send_move(16'd0, 16'd31, 16'd31, -21'sd1, 1'b1);
    // Unit ids at and past the limit give nothing.
    send_move(16'd4096, 16'd100, 16'd100, 21'sd0, 1'b1);
    send_move(16'hFFFF, 16'd0, 16'd0, 21'sd5, 1'b0);
    // Unchanged area, without and with the flag, in the middle and at the corner.
    send_move(16'd7, 16'd100, 16'd100, 21'sd51, 1'b0);
    send_move(16'd7, 16'd100, 16'd100, 21'sd51, 1'b1);
    send_move(16'd8, 16'd480, 16'd480, 21'sd255, 1'b1);
    send_move(16'd8, 16'd0, 16'd0, 21'sd0, 1'b1);
    // The plus-one crosses into the next area at the last position of a column.
    send_move(16'd9, 16'd31, 16'd0, 21'sd0, 1'b0);
    // Moves by one area straight and diagonally.
    send_move(16'd10, 16'd132, 16'd100, 21'sd51, 1'b0);
    send_move(16'd10, 16'd132, 16'd132, 21'sd51, 1'b1);
    send_move(16'd11, 16'd0, 16'd0, 21'sd17, 1'b0);
    // Far jumps: partial neighborhoods and the full nine leaves plus nine enters.
    send_move(16'd12, 16'd300, 16'd300, 21'sd0, 1'b0);
    send_move(16'd12, 16'd300, 16'd300, 21'sd51, 1'b0);
    // Positions past the map clamp; the new column can wrap past the grid.
    send_move(16'd13, 16'hFFFF, 16'hFFFF, 21'sd255, 1'b0);
    send_move(16'd14, 16'd511, 16'd0, 21'sd15, 1'b0);
    send_move(16'd15, 16'hFFFF, 16'd0, 21'sd16, 1'b1);
    // Largest old area lies outside the grid.
    send_move(16'd16, 16'd0, 16'd0, 21'sd1048575, 1'b0);
    send_move(16'd17, 16'd200, 16'd40, 21'sd1048575, 1'b1);
    drain_and_settle();
  endtask

  // Smallest grid, map and id range: everything lands in area 0.
  task automatic test_min_grid();
    load_grid(1, 1, 1, 1, 1);
    run_random_moves(50);
  endtask

  // A 1024 x 1024 grid and the largest map: new areas run past 20 bits.
  task automatic test_max_grid();
    load_grid(1024, 1024, 65535, 65535, 65535);
    run_random_moves(100);
  endtask

  // Random grids, some long and thin in either direction.
  task automatic test_random_grids();
    int p;
    for (p = 0; p < 3; p++) begin
      load_grid($urandom_range(1, (p == 2) ? 1024 : 40), $urandom_range(1, (p == 1) ? 1024 : 40),
                $urandom_range(1, (p == 0) ? 300 : 4000), $urandom_range(1, 4000),
                $urandom_range(16, 65535));
      run_random_moves(100);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_grid();
    test_min_grid();
    test_max_grid();
    test_random_grids();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ngac_pkg.sv
rtl/core/ngac_div.sv
rtl/core/ngac_front.sv
rtl/core/ngac_queue.sv
rtl/core/ngac_back.sv
rtl/core/nine_grid_area_change_diff_top.sv
tb/sv/tb_nine_grid_area_change_diff_top.sv
